[rtl/core/assert_macros.svh]
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// implication whose consequent is checked in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/spcf_pkg.sv]
package spcf_pkg;

  // crc-16 reflected polynomial and seed
  localparam logic [15:0] CRC_POLY = 16'h8408;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // packet header bytes
  localparam logic [7:0] HDR_COMMAND = 8'hC0;
  localparam logic [7:0] HDR_DATA    = 8'h3F;

  // results one transaction can produce
  localparam int unsigned MAX_RESULTS = 5;
  localparam int unsigned RES_CNT_W   = $clog2(MAX_RESULTS + 1);
  localparam int unsigned RES_IDX_W   = $clog2(MAX_RESULTS);

  // result counts per kind of transaction
  localparam logic [RES_CNT_W-1:0] CNT_NONE    = RES_CNT_W'(0);
  localparam logic [RES_CNT_W-1:0] CNT_ONE     = RES_CNT_W'(1);
  localparam logic [RES_CNT_W-1:0] CNT_TWO     = RES_CNT_W'(2);
  localparam logic [RES_CNT_W-1:0] CNT_THREE   = RES_CNT_W'(3);
  localparam logic [RES_CNT_W-1:0] CNT_TRAILER = RES_CNT_W'(2);

  // held byte fill levels in check mode
  localparam logic [1:0] HELD_EMPTY = 2'd0;
  localparam logic [1:0] HELD_ONE   = 2'd1;
  localparam logic [1:0] HELD_FULL  = 2'd2;

  typedef enum logic [1:0] {
    FUNC_CMD   = 2'd0,
    FUNC_DATA  = 2'd1,
    FUNC_CHECK = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic {
    KIND_BYTE    = 1'b0,
    KIND_VERDICT = 1'b1
  } kind_t;

  // one byte step of the reflected crc, eight shift steps
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // crc after the fixed header byte of a fresh packet
  localparam logic [15:0] CRC_AFTER_CMD_HDR  = crc_byte(CRC_INIT, HDR_COMMAND);
  localparam logic [15:0] CRC_AFTER_DATA_HDR = crc_byte(CRC_INIT, HDR_DATA);

  typedef struct packed {
    func_t      func;
    logic       first;
    logic       last;
    logic [7:0] data_byte;
    logic [7:0] control_bits;
    logic [3:0] cmd_length;
    logic       crc_enable;
  } item_t;

  typedef struct packed {
    logic [15:0] crc;
    logic [7:0]  held0;
    logic [7:0]  held1;
    logic [1:0]  held_count;
  } state_t;

  typedef struct packed {
    logic [RES_CNT_W-1:0]        count;
    kind_t                       kind;
    logic                        ok;
    logic [MAX_RESULTS-1:0][7:0] bytes;
  } step_t;

endpackage

[rtl/core/spcf_step.sv]
module spcf_step
  import spcf_pkg::*;
(
  input  item_t  item,
  input  state_t state,
  output state_t state_next,
  output step_t  res
);

  logic [15:0] crc_base;
  logic [15:0] crc_pre_data;
  logic [15:0] crc_post_data;
  logic [7:0]  ctl_byte;
  logic        trailer;
  logic [1:0]  held_base;
  logic [15:0] chk_crc;
  logic [7:0]  chk_held0;
  logic [7:0]  chk_held1;
  logic [1:0]  chk_count;
  logic        chk_ok;

  // framing: crc over header, control and payload bytes
  assign crc_base = item.first ? CRC_INIT : state.crc;
  assign ctl_byte = item.control_bits | {4'b0000, item.cmd_length};
  assign trailer  = item.last && item.crc_enable;

  always_comb begin
    if (item.first && item.func == FUNC_CMD) begin
      crc_pre_data = crc_byte(CRC_AFTER_CMD_HDR, ctl_byte);
    end else if (item.first) begin
      crc_pre_data = CRC_AFTER_DATA_HDR;
    end else begin
      crc_pre_data = state.crc;
    end
  end

  assign crc_post_data = crc_byte(crc_pre_data, item.data_byte);

  // check: delay the crc by two bytes so the trailer stays out of it
  assign held_base = item.first ? HELD_EMPTY : state.held_count;

  always_comb begin
    chk_crc   = crc_base;
    chk_held0 = state.held0;
    chk_held1 = state.held1;
    chk_count = HELD_FULL;
    if (held_base[1]) begin
      chk_crc   = crc_byte(crc_base, state.held0);
      chk_held0 = state.held1;
      chk_held1 = item.data_byte;
    end else if (held_base == HELD_EMPTY) begin
      chk_held0 = item.data_byte;
      chk_count = HELD_ONE;
    end else begin
      chk_held1 = item.data_byte;
    end
  end

  always_comb begin
    if (!item.crc_enable) begin
      chk_ok = 1'b1;
    end else if (!chk_count[1]) begin
      chk_ok = 1'b0;
    end else begin
      chk_ok = (chk_crc == {chk_held1, chk_held0});
    end
  end

  // result list and next state per function
  always_comb begin
    state_next = state;
    res.count  = CNT_NONE;
    res.kind   = KIND_BYTE;
    res.ok     = 1'b0;
    res.bytes  = '0;
    unique case (item.func) inside
      FUNC_CMD, FUNC_DATA: begin
        state_next.crc = crc_post_data;
        if (item.first && item.func == FUNC_CMD) begin
          res.bytes[0] = HDR_COMMAND;
          res.bytes[1] = ctl_byte;
          res.bytes[2] = item.data_byte;
          res.bytes[3] = crc_post_data[7:0];
          res.bytes[4] = crc_post_data[15:8];
          res.count    = CNT_THREE;
        end else if (item.first) begin
          res.bytes[0] = HDR_DATA;
          res.bytes[1] = item.data_byte;
          res.bytes[2] = crc_post_data[7:0];
          res.bytes[3] = crc_post_data[15:8];
          res.count    = CNT_TWO;
        end else begin
          res.bytes[0] = item.data_byte;
          res.bytes[1] = crc_post_data[7:0];
          res.bytes[2] = crc_post_data[15:8];
          res.count    = CNT_ONE;
        end
        if (trailer) begin
          res.count = res.count + CNT_TRAILER;
        end
      end
      FUNC_CHECK: begin
        state_next.crc        = chk_crc;
        state_next.held0      = chk_held0;
        state_next.held1      = chk_held1;
        state_next.held_count = chk_count;
        res.kind              = KIND_VERDICT;
        res.ok                = chk_ok;
        res.count             = item.last ? CNT_ONE : CNT_NONE;
      end
      FUNC_NONE: begin
        res.count = CNT_NONE;
      end
      default: begin
        res.count = CNT_NONE;
      end
    endcase
  end

endmodule

[rtl/core/spi_packet_crc_framer.sv]
// channel  | handshake                | payload
// in       | in_valid / in_stall      | func first last data_byte control_bits cmd_length
//          |                          | crc_enable
// out      | out_valid / out_stall    | out_byte out_last result_kind crc_ok
//
// an input transaction passes an input register, one pass of combinational
// logic, then a result buffer that emits one result per cycle unless out_stall holds it
// a transaction gives 1 to 5 results, or none
// first result is on the outputs once its transaction has left the input register for the result buffer
// reset seeds the crc with all ones, clears the held bytes, empties both stages
// a stalled output holds the buffer; the input register takes one more, then stalls
module spi_packet_crc_framer
  import spcf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] func,
  input  logic       first,
  input  logic       last,
  input  logic [7:0] data_byte,
  input  logic [7:0] control_bits,
  input  logic [3:0] cmd_length,
  input  logic       crc_enable,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       result_kind,
  output logic       crc_ok
);

  logic                        in_full;
  item_t                       in_item;
  state_t                      state;
  state_t                      state_next;
  step_t                       step;
  logic [MAX_RESULTS-1:0][7:0] res_bytes;
  logic [RES_CNT_W-1:0]        res_count;
  logic [RES_IDX_W-1:0]        res_ptr;
  kind_t                       res_kind;
  logic                        res_ok;
  logic                        out_fire;
  logic                        res_free;
  logic                        move;

  // per transaction result list and next crc state
  spcf_step u_step (
    .item       (in_item),
    .state      (state),
    .state_next (state_next),
    .res        (step)
  );

  // output side of the result buffer
  assign out_valid   = (res_count != CNT_NONE);
  assign out_byte    = res_bytes[res_ptr];
  assign out_last    = (res_ptr == RES_IDX_W'(res_count - CNT_ONE));
  assign result_kind = res_kind;
  assign crc_ok      = res_ok;

  // handshake
  assign out_fire = out_valid && !out_stall;
  assign res_free = !out_valid || (out_fire && out_last);
  assign move     = in_full && res_free;
  assign in_stall = in_full && !res_free;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_item.func         <= func_t'(func);
      in_item.first        <= first;
      in_item.last         <= last;
      in_item.data_byte    <= data_byte;
      in_item.control_bits <= control_bits;
      in_item.cmd_length   <= cmd_length;
      in_item.crc_enable   <= crc_enable;
    end
  end

  // crc and held byte state
  always_ff @(posedge clk) begin
    if (rst) begin
      state.crc        <= CRC_INIT;
      state.held0      <= 8'h00;
      state.held1      <= 8'h00;
      state.held_count <= HELD_EMPTY;
    end else if (move) begin
      state <= state_next;
    end
  end

  // result buffer control
  always_ff @(posedge clk) begin
    if (rst) begin
      res_count <= CNT_NONE;
      res_ptr   <= '0;
    end else if (move) begin
      res_count <= step.count;
      res_ptr   <= '0;
    end else if (out_fire) begin
      if (out_last) begin
        res_count <= CNT_NONE;
        res_ptr   <= '0;
      end else begin
        res_ptr <= res_ptr + RES_IDX_W'(1);
      end
    end
  end

  // result buffer payload
  always_ff @(posedge clk) begin
    if (move) begin
      res_bytes <= step.bytes;
      res_kind  <= step.kind;
      res_ok    <= step.ok;
    end
  end

endmodule

[rtl/core/spcf_checker.sv]
`include "assert_macros.svh"

module spcf_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_last,
  input logic       result_kind,
  input logic       crc_ok
);

  // a stalled result keeps its payload
  `ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_byte) && $stable(out_last)
      && $stable(result_kind) && $stable(crc_ok), "out payload moved under stall")

  // a verdict is the only result of its transaction and carries no byte
  `ASSERT_IMPL(a_verdict_single, out_valid && result_kind,
    out_last && (out_byte == 8'h00), "verdict not single or byte nonzero")

  // framed bytes never flag a crc match
  `ASSERT_IMPL(a_byte_no_ok, out_valid && !result_kind, !crc_ok, "framed byte with crc_ok set")

  // input only stalls while results wait to be taken
  `ASSERT_IMPL(a_stall_cause, in_stall, out_valid, "input stalled with no pending result")

endmodule

bind spi_packet_crc_framer spcf_checker u_spcf_checker (.*);

[verif/tb_spi_packet_crc_framer.sv]
`timescale 1ns / 100ps

module tb_spi_packet_crc_framer;
  import spcf_pkg::*;

  // one expected output transaction
  typedef struct {
    logic [7:0] byte_val;
    logic       last_flag;
    kind_t      kind;
    logic       ok;
  } framer_result_t;

  // crc framer predictor and result store
  class framer_scoreboard;
    logic [15:0]    crc_acc;
    logic [7:0]     held_q [2];
    int unsigned    held_cnt;
    framer_result_t pending [$];
    int unsigned    mismatches;
    int unsigned    results_seen;
    int unsigned    verdicts_pass;
    int unsigned    verdicts_fail;

    function new();
      crc_acc = CRC_INIT;
      held_q[0] = 8'h00;
      held_q[1] = 8'h00;
      held_cnt = 0;
      mismatches = 0;
      results_seen = 0;
      verdicts_pass = 0;
      verdicts_fail = 0;
    endfunction

    // reflected crc-16 over one byte, lsb first
    static function logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      repeat (8) begin
        if (c[0]) c = (c >> 1) ^ CRC_POLY;
        else c = c >> 1;
      end
      return c;
    endfunction

    // accepted input transaction: advance the state, queue its results
    function void note_input(item_t it);
      logic [7:0] seq [$];
      logic       ok;
      case (it.func)
        FUNC_NONE: begin
          return;
        end
        FUNC_CHECK: begin
          if (it.first) begin
            crc_acc = CRC_INIT;
            held_cnt = 0;
          end
          // the two newest bytes stay out of the crc
          if (held_cnt >= 2) begin
            crc_acc = crc_step(crc_acc, held_q[0]);
            held_q[0] = held_q[1];
            held_q[1] = it.data_byte;
          end else begin
            held_q[held_cnt] = it.data_byte;
            held_cnt++;
          end
          if (it.last) begin
            if (!it.crc_enable) ok = 1'b1;
            else if (held_cnt < 2) ok = 1'b0;
            else ok = (crc_acc == {held_q[1], held_q[0]});
            pending.push_back('{8'h00, 1'b1, KIND_VERDICT, ok});
          end
        end
        default: begin
          if (it.first) begin
            crc_acc = CRC_INIT;
            if (it.func == FUNC_CMD) begin
              seq.push_back(HDR_COMMAND);
              seq.push_back(it.control_bits | {4'h0, it.cmd_length});
            end else begin
              seq.push_back(HDR_DATA);
            end
          end
          seq.push_back(it.data_byte);
          foreach (seq[i]) crc_acc = crc_step(crc_acc, seq[i]);
          // trailer, low byte first
          if (it.last && it.crc_enable) begin
            seq.push_back(crc_acc[7:0]);
            seq.push_back(crc_acc[15:8]);
          end
          foreach (seq[i]) pending.push_back('{seq[i], (i == seq.size() - 1), KIND_BYTE, 1'b0});
        end
      endcase
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= 30) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // accepted output transaction against the oldest expectation
    task check_result(logic [7:0] b, logic lst, logic kind, logic ok);
      framer_result_t want;
      results_seen++;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected result byte %02h kind %0d", b, kind));
        return;
      end
      want = pending.pop_front();
      if (b !== want.byte_val)
        report_mismatch($sformatf("out_byte %02h, want %02h", b, want.byte_val));
      if (lst !== want.last_flag)
        report_mismatch($sformatf("out_last %0b, want %0b", lst, want.last_flag));
      if (kind !== want.kind)
        report_mismatch($sformatf("result_kind %0b, want %0b", kind, want.kind));
      if (ok !== want.ok)
        report_mismatch($sformatf("crc_ok %0b, want %0b", ok, want.ok));
      if (want.kind == KIND_VERDICT) begin
        if (want.ok) verdicts_pass++;
        else verdicts_fail++;
      end
    endtask
  endclass

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] func;
  logic       first;
  logic       last;
  logic [7:0] data_byte;
  logic [7:0] control_bits;
  logic [3:0] cmd_length;
  logic       crc_enable;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       out_last;
  logic       result_kind;
  logic       crc_ok;

  framer_scoreboard sb;
  int unsigned      burst_left;
  int unsigned      items_sent;
  int unsigned      packets_framed;
  int unsigned      frames_checked;

  spi_packet_crc_framer u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .first        (first),
    .last         (last),
    .data_byte    (data_byte),
    .control_bits (control_bits),
    .cmd_length   (cmd_length),
    .crc_enable   (crc_enable),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_last     (out_last),
    .result_kind  (result_kind),
    .crc_ok       (crc_ok)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  function automatic item_t mk_item(func_t f, logic fst, logic lst, logic [7:0] d,
                                    logic [7:0] ctrl, logic [3:0] len, logic ce);
    item_t it;
    it.func = f;
    it.first = fst;
    it.last = lst;
    it.data_byte = d;
    it.control_bits = ctrl;
    it.cmd_length = len;
    it.crc_enable = ce;
    return it;
  endfunction

  // one input transaction, sent in bursts with random gaps between them
  task automatic drive_item(item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    func         <= it.func;
    first        <= it.first;
    last         <= it.last;
    data_byte    <= it.data_byte;
    control_bits <= it.control_bits;
    cmd_length   <= it.cmd_length;
    crc_enable   <= it.crc_enable;
    in_valid     <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_input(it);
    if (it.func != FUNC_NONE) items_sent++;
  endtask

  // command or data packet of n bytes, crc trailer chosen on the last byte
  task automatic send_packet(func_t f, int n, logic ce);
    for (int i = 0; i < n; i++)
      drive_item(mk_item(f, i == 0, i == n - 1, 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)), 4'($urandom_range(1, 15)),
                         (i == n - 1) ? ce : 1'($urandom_range(0, 1))));
    packets_framed++;
  endtask

  // received frame: payload plus its crc, optionally with one bit flipped
  task automatic send_check_frame(int n_pay, logic ce, logic corrupt);
    logic [7:0]  frame [$];
    logic [7:0]  b;
    logic [15:0] c;
    int          k;
    c = CRC_INIT;
    for (int i = 0; i < n_pay; i++) begin
      b = 8'($urandom_range(0, 255));
      frame.push_back(b);
      c = framer_scoreboard::crc_step(c, b);
    end
    frame.push_back(c[7:0]);
    frame.push_back(c[15:8]);
    if (corrupt) begin
      k = $urandom_range(0, frame.size() - 1);
      frame[k] = frame[k] ^ 8'(1 << $urandom_range(0, 7));
    end
    foreach (frame[i])
      drive_item(mk_item(FUNC_CHECK, i == 0, i == frame.size() - 1, frame[i],
                         8'($urandom_range(0, 255)), 4'($urandom_range(1, 15)),
                         (i == frame.size() - 1) ? ce : 1'($urandom_range(0, 1))));
    frames_checked++;
  endtask

  task automatic send_noise();
    drive_item(mk_item(func_t'(2'($urandom_range(0, 3))), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 4'($urandom_range(1, 15)),
                       1'($urandom_range(0, 1))));
  endtask

  // receiver: checks accepted results and stalls in phases of its own
  initial begin
    int unsigned phase_left;
    int unsigned stall_mode;
    int unsigned stall_run;
    logic        nxt;
    phase_left = 0;
    stall_mode = 0;
    stall_run = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall)
        sb.check_result(out_byte, out_last, result_kind, crc_ok);
      if (phase_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        phase_left = $urandom_range(20, 80);
      end
      phase_left--;
      case (stall_mode)
        0: nxt = 1'b0;
        1: nxt = ($urandom_range(0, 2) == 0);
        default: begin
          if (stall_run > 0) begin
            stall_run--;
            nxt = 1'b1;
          end else if ($urandom_range(0, 5) == 0) begin
            stall_run = $urandom_range(0, 7);
            nxt = 1'b1;
          end else begin
            nxt = 1'b0;
          end
        end
      endcase
      out_stall <= nxt;
    end
  end

  // stimulus
  initial begin
    int unsigned target;
    int unsigned pick;
    sb = new();
    burst_left = 0;
    items_sent = 0;
    packets_framed = 0;
    frames_checked = 0;
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    func         <= FUNC_CMD;
    first        <= 1'b0;
    last         <= 1'b0;
    data_byte    <= 8'h00;
    control_bits <= 8'h00;
    cmd_length   <= 4'h1;
    crc_enable   <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // single byte command packets at the field extremes, five results with crc, three without
    drive_item(mk_item(FUNC_CMD, 1'b1, 1'b1, 8'h00, 8'hFF, 4'hF, 1'b1));
    drive_item(mk_item(FUNC_CMD, 1'b1, 1'b1, 8'hFF, 8'h00, 4'h1, 1'b0));
    // control byte with low bits already set, then a continuation byte
    drive_item(mk_item(FUNC_CMD, 1'b1, 1'b0, 8'hA5, 8'h0F, 4'h5, 1'b0));
    drive_item(mk_item(FUNC_CMD, 1'b0, 1'b1, 8'h5A, 8'h00, 4'h1, 1'b1));
    // data packets with and without trailer
    drive_item(mk_item(FUNC_DATA, 1'b1, 1'b1, 8'hFF, 8'h00, 4'h1, 1'b1));
    drive_item(mk_item(FUNC_DATA, 1'b1, 1'b0, 8'h00, 8'hFF, 4'hF, 1'b1));
    // unused selector in the middle of a packet
    drive_item(mk_item(FUNC_NONE, 1'b1, 1'b1, 8'h77, 8'h55, 4'hA, 1'b1));
    drive_item(mk_item(FUNC_DATA, 1'b0, 1'b1, 8'h80, 8'h00, 4'h1, 1'b0));
    // received frames: good crc, bad crc, crc not checked
    send_check_frame(2, 1'b1, 1'b0);
    send_check_frame(3, 1'b1, 1'b1);
    send_check_frame(2, 1'b0, 1'b1);
    // short frame of a single byte
    drive_item(mk_item(FUNC_CHECK, 1'b1, 1'b1, 8'h12, 8'h00, 4'h1, 1'b1));
    // check bytes held, then a data byte carrying on without first
    drive_item(mk_item(FUNC_CHECK, 1'b1, 1'b0, 8'h34, 8'h00, 4'h1, 1'b0));
    drive_item(mk_item(FUNC_DATA, 1'b0, 1'b1, 8'h56, 8'h00, 4'h1, 1'b1));
    // check continuing without first after framing
    drive_item(mk_item(FUNC_CHECK, 1'b0, 1'b1, 8'hC3, 8'h00, 4'h1, 1'b1));

    // random part: mostly well-formed packets and frames, some noise
    target = 230;
    while (items_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) send_packet(FUNC_CMD, $urandom_range(1, 6), 1'($urandom_range(0, 3) != 0));
      else if (pick < 55) send_packet(FUNC_DATA, $urandom_range(1, 8),
                                      1'($urandom_range(0, 3) != 0));
      else if (pick < 82) send_check_frame($urandom_range(0, 6), 1'($urandom_range(0, 4) != 0),
                                           1'($urandom_range(0, 3) == 0));
      else if (pick < 86)
        drive_item(mk_item(FUNC_CHECK, 1'b1, 1'b1, 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)), 4'($urandom_range(1, 15)), 1'b1));
      else
        repeat ($urandom_range(1, 4)) send_noise();
    end
    in_valid <= 1'b0;

    // drain
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("sent %0d transactions: %0d framed packets, %0d received frames",
             items_sent, packets_framed, frames_checked);
    $display("checked %0d results, %0d crc verdicts passing and %0d failing",
             sb.results_seen, sb.verdicts_pass, sb.verdicts_fail);
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
